### hdl/bfc_pkg.sv
// Shared types and constants of the Brenner focus block.
package bfc_pkg;

   localparam int PIX_W       = 8;
   localparam int GEO_W       = 12;
   localparam int CSR_W       = 21;
   localparam int CSR_ADDR_W  = 2;
   localparam int THR_W       = 21;
   localparam int SCORE_W     = 21;
   localparam int SCORE_CNT_W = $clog2(SCORE_W);
   localparam int SQ_W        = 2 * PIX_W;
   localparam int SUM_W       = 40;
   localparam int AREA_W      = 2 * GEO_W;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;
   localparam int Q_DEPTH     = 2;
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   // floor(n / 3) == (n * DIV3_MUL) >> DIV3_SHIFT for every n below 2^17.
   localparam int DIV3_W      = 16;
   localparam int DIV3_MUL    = 43691;
   localparam int DIV3_SHIFT  = 17;

   localparam int RST_FRAME_WIDTH  = 1280;
   localparam int RST_FRAME_HEIGHT = 720;
   localparam int RST_THRESHOLD    = 8000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_WIDTH     = 2'd0,
      CSR_FRAME_HEIGHT    = 2'd1,
      CSR_FOCUS_THRESHOLD = 2'd2
   } bfc_csr_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_HOLD
   } bfc_back_state_type;

   // Frame and ROI bounds, all in pixel units.
   typedef struct packed {
      logic [GEO_W-1:0] col_last;
      logic [GEO_W-1:0] col_lo;
      logic [GEO_W-1:0] col_hi;
      logic [GEO_W-1:0] col_pair;
      logic [GEO_W-1:0] row_last;
      logic [GEO_W-1:0] row_lo;
      logic [GEO_W-1:0] row_hi;
      logic [GEO_W-1:0] row_pair;
   } bfc_geom_type;

endpackage

### hdl/bfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hdl/bfc_front.sv
// Pixel front end: raster counters, line stores, ROI pair tests and the square sum.
module bfc_front
   import bfc_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bfc_geom_type         geom,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [PIX_W-1:0]     req_pixel,
   input  logic                 req_frame_start,
   input  logic [Q_CNT_W-1:0]   q_count,
   output logic                 push_valid,
   output logic [SUM_W-1:0]     push_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int CMP_C = (CW > GEO_W) ? CW : GEO_W;
   localparam int CMP_R = (RW > GEO_W) ? RW : GEO_W;
   localparam int PEND_W = Q_CNT_W + 1;

   logic              req_fire;
   logic [CW-1:0]     col_ff, col_in, c_cur;
   logic [RW-1:0]     row_ff, row_in, r_cur;
   logic              col_end, row_end;

   logic              a_valid_ff, a_valid_in;
   logic [PIX_W-1:0]  a_pix_ff;
   logic [CW-1:0]     a_col_ff;
   logic [RW-1:0]     a_row_ff;
   logic              a_start_ff;
   logic              a_last_ff;

   logic [SQ_W-1:0]   ram_rdata, rd_eff;
   logic              byp_valid_ff, byp_valid_in;
   logic [SQ_W-1:0]   byp_data_ff;
   logic [PIX_W-1:0]  rp0_ff, rp1_ff;

   logic              col_roi, row_roi, h_pair, v_pair;
   logic [PIX_W-1:0]  dh, dv, older;
   logic [SQ_W-1:0]   sqh, sqv;

   logic              b_valid_ff;
   logic [SQ_W-1:0]   b_sqh_ff, b_sqv_ff;
   logic              b_start_ff, b_last_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in, sum_acc;
   logic [PEND_W-1:0] pending;

   // Count every frame end already accepted so the queue can never overflow.
   assign pending = PEND_W'(q_count) + PEND_W'(a_valid_ff && a_last_ff)
                  + PEND_W'(b_valid_ff && b_last_ff);
   assign req_tready = (pending < PEND_W'(Q_DEPTH));
   assign req_fire   = req_tvalid && req_tready;

   assign c_cur   = req_frame_start ? '0 : col_ff;
   assign r_cur   = req_frame_start ? '0 : row_ff;
   assign col_end = CMP_C'(c_cur) >= CMP_C'(geom.col_last);
   assign row_end = CMP_R'(r_cur) >= CMP_R'(geom.row_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : r_cur + RW'(1);
         end else begin
            col_in = c_cur + CW'(1);
            row_in = r_cur;
         end
      end
   end

   assign a_valid_in = req_fire;

   // Each entry holds the pixel two rows up in the high byte and one row up in the low byte.
   bfc_ram #(
      .WIDTH (SQ_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (a_valid_ff),
      .wr_addr (a_col_ff),
      .wr_data ({rd_eff[PIX_W-1:0], a_pix_ff}),
      .rd_en   (req_fire),
      .rd_addr (c_cur),
      .rd_data (ram_rdata)
   );

   // A read that meets a write to the same column gets the new entry.
   assign rd_eff       = byp_valid_ff ? byp_data_ff : ram_rdata;
   assign byp_valid_in = a_valid_ff && (a_col_ff == c_cur);
   assign older        = rd_eff[SQ_W-1:PIX_W];

   assign col_roi = (CMP_C'(a_col_ff) >= CMP_C'(geom.col_lo))
                 && (CMP_C'(a_col_ff) <  CMP_C'(geom.col_hi));
   assign row_roi = (CMP_R'(a_row_ff) >= CMP_R'(geom.row_lo))
                 && (CMP_R'(a_row_ff) <  CMP_R'(geom.row_hi));
   assign h_pair  = col_roi && row_roi && (CMP_C'(a_col_ff) >= CMP_C'(geom.col_pair));
   assign v_pair  = col_roi && row_roi && (CMP_R'(a_row_ff) >= CMP_R'(geom.row_pair));

   assign dh  = (a_pix_ff >= rp1_ff) ? a_pix_ff - rp1_ff : rp1_ff - a_pix_ff;
   assign dv  = (a_pix_ff >= older)  ? a_pix_ff - older  : older - a_pix_ff;
   assign sqh = h_pair ? SQ_W'(dh) * SQ_W'(dh) : '0;
   assign sqv = v_pair ? SQ_W'(dv) * SQ_W'(dv) : '0;

   assign sum_acc    = (b_start_ff ? '0 : sum_ff) + SUM_W'(b_sqh_ff) + SUM_W'(b_sqv_ff);
   assign push_valid = b_valid_ff && b_last_ff;
   assign push_data  = sum_acc;

   always_comb begin
      sum_in = sum_ff;
      if (b_valid_ff) begin
         sum_in = b_last_ff ? '0 : sum_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         byp_valid_ff <= 1'b0;
         rp0_ff       <= '0;
         rp1_ff       <= '0;
         sum_ff       <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= a_valid_ff;
         byp_valid_ff <= byp_valid_in;
         sum_ff       <= sum_in;
         if (a_valid_ff) begin
            rp1_ff <= rp0_ff;
            rp0_ff <= a_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_pix_ff   <= req_pixel;
         a_col_ff   <= c_cur;
         a_row_ff   <= r_cur;
         a_start_ff <= req_frame_start;
         a_last_ff  <= col_end && row_end;
      end
      byp_data_ff <= {rd_eff[PIX_W-1:0], a_pix_ff};
      b_sqh_ff    <= sqh;
      b_sqv_ff    <= sqv;
      b_start_ff  <= a_start_ff;
      b_last_ff   <= a_last_ff;
   end

endmodule

### hdl/bfc_queue.sv
// Short queue of finished frame sums between the front end and the divider.
module bfc_queue
   import bfc_pkg::*;
#(
   parameter int WIDTH = 40
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  logic [WIDTH-1:0]   push_data,
   input  logic               pop,
   output logic               out_valid,
   output logic [WIDTH-1:0]   out_data,
   output logic [Q_CNT_W-1:0] count
);

   localparam int PW = $clog2(Q_DEPTH);

   logic [WIDTH-1:0]   entry_ff [Q_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign do_push   = push_valid && (count_ff < Q_CNT_W'(Q_DEPTH));
   assign do_pop    = pop && (count_ff != '0);
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/bfc_back.sv
// Score back end: sum over ROI area by restoring division, saturation and threshold.
module bfc_back
   import bfc_pkg::*;
#(
   parameter int FRACTION_BITS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  logic [SUM_W-1:0]    q_data,
   output logic                pop,
   input  logic [AREA_W-1:0]   area,
   input  logic [THR_W-1:0]    threshold,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SCORE_W-1:0]  score,
   output logic                focus_hit
);

   localparam int NW    = SUM_W + FRACTION_BITS;
   localparam int HI_W  = NW - SCORE_W;
   localparam int CMP_W = (HI_W > AREA_W) ? HI_W : AREA_W;

   bfc_back_state_type state_ff, state_in;

   logic [NW-1:0]          num_full;
   logic [HI_W-1:0]        num_hi;
   logic                   sat;
   logic [AREA_W-1:0]      rem_ff;
   logic [SCORE_W-1:0]     num_ff;
   logic [SCORE_W-1:0]     quo_ff, quo_next;
   logic [SCORE_CNT_W-1:0] cnt_ff;
   logic [AREA_W:0]        trial, diff;
   logic                   ge;
   logic [SCORE_W-1:0]     score_ff;
   logic                   focus_ff;

   assign num_full = NW'(q_data) << FRACTION_BITS;
   assign num_hi   = num_full[NW-1:SCORE_W];
   // The quotient overflows the score exactly when the high part reaches the area.
   assign sat      = CMP_W'(num_hi) >= CMP_W'(area);

   assign trial    = {rem_ff, num_ff[SCORE_W-1]};
   assign ge       = trial >= {1'b0, area};
   assign diff     = trial - {1'b0, area};
   assign quo_next = {quo_ff[SCORE_W-2:0], ge};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               state_in = sat ? BK_HOLD : BK_DIV;
            end
         end
         BK_DIV: begin
            if (cnt_ff == '0) begin
               state_in = BK_HOLD;
            end
         end
         BK_HOLD: begin
            if (rsp_tready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop        = (state_ff == BK_IDLE) && q_valid;
      rsp_tvalid = (state_ff == BK_HOLD);
   end

   assign score     = score_ff;
   assign focus_hit = focus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (sat) begin
                  score_ff <= '1;
                  focus_ff <= ({SCORE_W{1'b1}} >= SCORE_W'(threshold));
               end
               rem_ff <= AREA_W'(num_hi);
               num_ff <= num_full[SCORE_W-1:0];
               quo_ff <= '0;
               cnt_ff <= SCORE_CNT_W'(SCORE_W - 1);
            end
         end
         BK_DIV: begin
            rem_ff <= ge ? AREA_W'(diff) : AREA_W'(trial);
            num_ff <= num_ff << 1;
            quo_ff <= quo_next;
            cnt_ff <= cnt_ff - SCORE_CNT_W'(1);
            if (cnt_ff == '0) begin
               score_ff <= quo_next;
               focus_ff <= (quo_next >= SCORE_W'(threshold));
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### hdl/brenner_focus_center_roi_top.sv
// Top level of the Brenner focus measure over the centered ROI of a mono frame.
//
// Request channel (req_): one 8-bit pixel per request in raster order, tuser
// marks the first pixel of a frame. Pixels are taken one per clock while req_tready is high.
// Response channel (rsp_): one response per frame at its last pixel, carrying
// the score (mean of squared distance-2 differences over the center third of
// the frame, 4 fraction bits, saturated) and the in-focus flag.
// Configuration (csr_): frame width, frame height and focus threshold, written
// by index while the block is idle; the ROI bounds are registered once more from the stored sizes.
// Path of a frame: after the edge that accepts its last pixel, the sum passes
// the front stages A and B, the queue write, the divider load and 21 divider
// steps before the response is presented; a saturated score skips the divider steps.
// The back end takes no new frame sum until its current response is taken, so
// frames shorter than its work on a frame sustain less than one pixel per clock.
// The sum queue holds two finished frames; when it and the front stages hold
// that many, req_tready drops until the divider takes one. A stalled response
// holds its value and keeps the divider idle.
// Synchronous reset clears counters, sum, queue and the divider, and loads
// the default 1280x720 geometry and threshold 8000.
module brenner_focus_center_roi_top
   import bfc_pkg::*;
#(
   parameter int MAX_WIDTH     = 2048,
   parameter int MAX_HEIGHT    = 2048,
   parameter int FRACTION_BITS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] pixel
   input  logic                  req_tuser,   // [0] frame_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [20:0] score, [23:21] zero
   output logic                  rsp_tuser,   // [0] focus_hit
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int GEO_MAX  = (1 << GEO_W) - 1;
   localparam int WCAP     = (MAX_WIDTH  > GEO_MAX) ? GEO_MAX : MAX_WIDTH;
   localparam int HCAP     = (MAX_HEIGHT > GEO_MAX) ? GEO_MAX : MAX_HEIGHT;
   localparam int RST_WSZ  = (RST_FRAME_WIDTH  > WCAP) ? WCAP : RST_FRAME_WIDTH;
   localparam int RST_HSZ  = (RST_FRAME_HEIGHT > HCAP) ? HCAP : RST_FRAME_HEIGHT;
   localparam int RST_WROI = RST_WSZ / 3;
   localparam int RST_HROI = RST_HSZ / 3;
   localparam int RST_X0   = (RST_WSZ - RST_WROI) / 2;
   localparam int RST_Y0   = (RST_HSZ - RST_HROI) / 2;
   localparam int PROD_W   = GEO_W + DIV3_W;

   logic [GEO_W-1:0]  wr_size, size_c, roi_c;
   logic [PROD_W-1:0] prod_c;
   logic [GEO_W-1:0]  wcap_c;

   logic [GEO_W-1:0]  wsz_ff, wroi_ff, wlast_ff;
   logic [GEO_W-1:0]  hsz_ff, hroi_ff, hlast_ff;
   logic [THR_W-1:0]  thr_ff;
   logic [GEO_W-1:0]  x0_c, y0_c;
   bfc_geom_type      geom_ff, geom_in;
   bfc_geom_type      geom_use;
   logic [AREA_W-1:0] area_ff;

   logic               push_valid;
   logic [SUM_W-1:0]   push_data;
   logic               q_valid, q_pop;
   logic [SUM_W-1:0]   q_data;
   logic [Q_CNT_W-1:0] q_count;
   logic [SCORE_W-1:0] score;
   logic               focus_hit;

   // Clamp the written size and take a third of it for the ROI extent.
   assign wr_size = csr_wdata[GEO_W-1:0];
   assign wcap_c  = (csr_addr == CSR_FRAME_WIDTH) ? GEO_W'(WCAP) : GEO_W'(HCAP);
   assign size_c  = (wr_size == '0) ? GEO_W'(1) : (wr_size > wcap_c) ? wcap_c : wr_size;
   assign prod_c  = PROD_W'(size_c) * PROD_W'(DIV3_MUL);
   assign roi_c   = (GEO_W'(prod_c >> DIV3_SHIFT) == '0) ? GEO_W'(1)
                                                         : GEO_W'(prod_c >> DIV3_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         wsz_ff   <= GEO_W'(RST_WSZ);
         wroi_ff  <= GEO_W'(RST_WROI);
         wlast_ff <= GEO_W'(RST_WSZ - 1);
         hsz_ff   <= GEO_W'(RST_HSZ);
         hroi_ff  <= GEO_W'(RST_HROI);
         hlast_ff <= GEO_W'(RST_HSZ - 1);
         thr_ff   <= THR_W'(RST_THRESHOLD);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH: begin
               wsz_ff   <= size_c;
               wroi_ff  <= roi_c;
               wlast_ff <= size_c - GEO_W'(1);
            end
            CSR_FRAME_HEIGHT: begin
               hsz_ff   <= size_c;
               hroi_ff  <= roi_c;
               hlast_ff <= size_c - GEO_W'(1);
            end
            CSR_FOCUS_THRESHOLD: begin
               thr_ff <= csr_wdata[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign x0_c = (wsz_ff - wroi_ff) >> 1;
   assign y0_c = (hsz_ff - hroi_ff) >> 1;

   always_comb begin
      geom_in.col_last = wlast_ff;
      geom_in.col_lo   = x0_c;
      geom_in.col_hi   = x0_c + wroi_ff;
      geom_in.col_pair = x0_c + GEO_W'(2);
      geom_in.row_last = hlast_ff;
      geom_in.row_lo   = y0_c;
      geom_in.row_hi   = y0_c + hroi_ff;
      geom_in.row_pair = y0_c + GEO_W'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.col_last <= GEO_W'(RST_WSZ - 1);
         geom_ff.col_lo   <= GEO_W'(RST_X0);
         geom_ff.col_hi   <= GEO_W'(RST_X0 + RST_WROI);
         geom_ff.col_pair <= GEO_W'(RST_X0 + 2);
         geom_ff.row_last <= GEO_W'(RST_HSZ - 1);
         geom_ff.row_lo   <= GEO_W'(RST_Y0);
         geom_ff.row_hi   <= GEO_W'(RST_Y0 + RST_HROI);
         geom_ff.row_pair <= GEO_W'(RST_Y0 + 2);
         area_ff          <= AREA_W'(RST_WROI * RST_HROI);
      end else begin
         geom_ff <= geom_in;
         area_ff <= AREA_W'(wroi_ff) * AREA_W'(hroi_ff);
      end
   end

   // The row-end tests need the new size at once; the ROI bounds follow in the next cycle.
   always_comb begin
      geom_use          = geom_ff;
      geom_use.col_last = wlast_ff;
      geom_use.row_last = hlast_ff;
   end

   bfc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .geom            (geom_use),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_pixel       (req_tdata[PIX_W-1:0]),
      .req_frame_start (req_tuser),
      .q_count         (q_count),
      .push_valid      (push_valid),
      .push_data       (push_data)
   );

   bfc_queue #(
      .WIDTH (SUM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (q_pop),
      .out_valid  (q_valid),
      .out_data   (q_data),
      .count      (q_count)
   );

   bfc_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .pop        (q_pop),
      .area       (area_ff),
      .threshold  (thr_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .score      (score),
      .focus_hit  (focus_hit)
   );

   assign rsp_tdata = RSP_DATA_W'(score);
   assign rsp_tuser = focus_hit;

endmodule

### hdl/bfc_checker.sv
// Port-level checks of the Brenner focus block, bound to its top level.
module bfc_checker
   import bfc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // A stalled response keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // The divider always passes through idle between two responses.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("response presented right after a taken response");

   // Reset empties the pipeline: no response and room for pixels.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   // The padding above the score is always zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:SCORE_W] == '0)
      else $error("nonzero padding in response data");

endmodule

bind brenner_focus_center_roi_top bfc_checker u_bfc_checker (.*);
